@@ rtl/ldm_pkg.sv @@
// Shared constants and types for the LED dot mask generator.
// No dependencies; used by the top level only.
package ldm_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int CNT_BITS       = 8;
    localparam int REG_IDX_BITS   = 2;

    // register reset values
    localparam int PANEL_WIDTH_RST  = 576;
    localparam int PANEL_HEIGHT_RST = 128;
    localparam int LED_COLUMNS_RST  = 72;
    localparam int LED_ROWS_RST     = 16;

    // geometry in thousandths of the pitch
    localparam int CORNER_MILLI = 102;
    localparam int INNER_MILLI  = 238;
    localparam int MILLI        = 1000;
    localparam int MILLI_HALF   = 500;
    localparam int MIN_PITCH    = 4;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_PANEL_WIDTH,
        REG_PANEL_HEIGHT,
        REG_LED_COLUMNS,
        REG_LED_ROWS
    } t_reg_idx;

endpackage

@@ rtl/ldm_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Standalone; the divisor is held stable by the caller while items are in flight.
module ldm_div_pipe #(
    parameter int DW = 16,
    parameter int VW = 8,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [DW-1:0] i_num,
    input  logic [VW-1:0] i_div,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [DW-1:0] o_quo,
    output logic [VW-1:0] o_rem,
    output logic [SW-1:0] o_side
);

    logic [DW-1:0] r_num  [DW];
    logic [VW-1:0] r_rem  [DW];
    logic [SW-1:0] r_side [DW];
    logic          r_vld  [DW];

    logic [DW-1:0] s_num  [DW];
    logic [VW-1:0] s_rem  [DW];
    logic [SW-1:0] s_side [DW];
    logic          s_vld  [DW];
    logic [DW-1:0] n_num  [DW];
    logic [VW-1:0] n_rem  [DW];

    genvar k;
    generate
        for (k = 0; k < DW; k++) begin : g_stage
            logic [VW:0] w_try;
            logic        w_ge;

            if (k == 0) begin : g_first
                assign s_num[k]  = i_num;
                assign s_rem[k]  = '0;
                assign s_side[k] = i_side;
                assign s_vld[k]  = i_vld;
            end else begin : g_next
                assign s_num[k]  = r_num[k-1];
                assign s_rem[k]  = r_rem[k-1];
                assign s_side[k] = r_side[k-1];
                assign s_vld[k]  = r_vld[k-1];
            end

            // shift in the next dividend bit, subtract if it fits
            assign w_try    = {s_rem[k], s_num[k][DW-1]};
            assign w_ge     = w_try >= {1'b0, i_div};
            assign n_rem[k] = w_ge ? VW'(w_try - {1'b0, i_div}) : w_try[VW-1:0];
            assign n_num[k] = {s_num[k][DW-2:0], w_ge};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= s_vld[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_num[k]  <= n_num[k];
                    r_rem[k]  <= n_rem[k];
                    r_side[k] <= s_side[k];
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[DW-1];
    assign o_quo  = r_num[DW-1];
    assign o_rem  = r_rem[DW-1];
    assign o_side = r_side[DW-1];

endmodule

@@ rtl/ldm_sqrt_pipe.sv @@
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Standalone; gives the floor root and the final remainder.
module ldm_sqrt_pipe #(
    parameter int RB = 8,
    parameter int SW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [2*RB-1:0] i_val,
    input  logic [SW-1:0]   i_side,
    output logic            o_vld,
    output logic [RB-1:0]   o_root,
    output logic [RB:0]     o_rem,
    output logic [SW-1:0]   o_side
);

    logic [2*RB-1:0] r_val  [RB];
    logic [RB:0]     r_rem  [RB];
    logic [RB-1:0]   r_root [RB];
    logic [SW-1:0]   r_side [RB];
    logic            r_vld  [RB];

    logic [2*RB-1:0] s_val  [RB];
    logic [RB:0]     s_rem  [RB];
    logic [RB-1:0]   s_root [RB];
    logic [SW-1:0]   s_side [RB];
    logic            s_vld  [RB];
    logic [RB:0]     n_rem  [RB];
    logic [RB-1:0]   n_root [RB];

    genvar k;
    generate
        for (k = 0; k < RB; k++) begin : g_stage
            logic [RB+1:0] w_try;
            logic [RB+1:0] w_trial;
            logic          w_ge;

            if (k == 0) begin : g_first
                assign s_val[k]  = i_val;
                assign s_rem[k]  = '0;
                assign s_root[k] = '0;
                assign s_side[k] = i_side;
                assign s_vld[k]  = i_vld;
            end else begin : g_next
                assign s_val[k]  = r_val[k-1];
                assign s_rem[k]  = r_rem[k-1];
                assign s_root[k] = r_root[k-1];
                assign s_side[k] = r_side[k-1];
                assign s_vld[k]  = r_vld[k-1];
            end

            // remainder stays below 2^RB until the last stage
            assign w_try     = {s_rem[k][RB-1:0], s_val[k][2*RB-1 -: 2]};
            assign w_trial   = {s_root[k], 2'b01};
            assign w_ge      = w_try >= w_trial;
            assign n_rem[k]  = w_ge ? (RB+1)'(w_try - w_trial) : w_try[RB:0];
            assign n_root[k] = {s_root[k][RB-2:0], w_ge};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= s_vld[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_val[k]  <= {s_val[k][2*RB-3:0], 2'b00};
                    r_rem[k]  <= n_rem[k];
                    r_root[k] <= n_root[k];
                    r_side[k] <= s_side[k];
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[RB-1];
    assign o_root = r_root[RB-1];
    assign o_rem  = r_rem[RB-1];
    assign o_side = r_side[RB-1];

endmodule

@@ rtl/led_dot_mask_generator.sv @@
// The bit-serial divider and root pipelines set the pipeline depth.
// Throughput: one pixel per cycle; the whole pipeline holds while a result is not taken.
// Reset (synchronous, active low) empties the pipeline and loads the default panel geometry.
// Depends on ldm_pkg, ldm_div_pipe and ldm_sqrt_pipe.
module led_dot_mask_generator #(
    parameter int COORD_BITS = ldm_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = ldm_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ldm_pkg::REG_IDX_BITS-1:0] i_cfg_index,
    input  logic [COORD_BITS-1:0]           i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [COORD_BITS-1:0]           i_pixel_x,
    input  logic [COORD_BITS-1:0]           i_pixel_y,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [7:0]                      o_coverage_level
);

    localparam int CB  = COORD_BITS;
    localparam int FB  = FRAC_BITS;
    localparam int CN  = ldm_pkg::CNT_BITS;
    localparam int PW  = CB + CN;
    localparam int DW1 = CB + FB + 9;
    localparam int KW  = CN + 10;
    localparam int LW  = CB + FB;
    localparam int DFW = CB + 3;
    localparam int DW2 = CB + FB + 2;
    localparam int RB  = LW + 1;
    localparam int CVW = LW + 4;
    localparam int LVW = FB + 9;
    localparam int CPW = CB + CN + 2;

    // ---------------- configuration ----------------
    logic [CB-1:0] r_width, r_height;
    logic [CN-1:0] r_cols, r_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CB'(ldm_pkg::PANEL_WIDTH_RST);
            r_height <= CB'(ldm_pkg::PANEL_HEIGHT_RST);
            r_cols   <= CN'(ldm_pkg::LED_COLUMNS_RST);
            r_rows   <= CN'(ldm_pkg::LED_ROWS_RST);
        end else if (i_cfg_we) begin
            unique case (ldm_pkg::t_reg_idx'(i_cfg_index))
                ldm_pkg::REG_PANEL_WIDTH:  r_width  <= i_cfg_data;
                ldm_pkg::REG_PANEL_HEIGHT: r_height <= i_cfg_data;
                ldm_pkg::REG_LED_COLUMNS:  r_cols   <= i_cfg_data[CN-1:0];
                ldm_pkg::REG_LED_ROWS:     r_rows   <= i_cfg_data[CN-1:0];
                default: ;
            endcase
        end
    end

    // derived geometry, first step: zero reads as one, pick the pitch axis
    logic [CB-1:0] n_w1, n_h1, r_w1, r_h1;
    logic [CN-1:0] n_c1, n_r1, r_c1, r_r1;
    logic          r_sel_x;

    assign n_w1 = (r_width  == '0) ? CB'(1) : r_width;
    assign n_h1 = (r_height == '0) ? CB'(1) : r_height;
    assign n_c1 = (r_cols   == '0) ? CN'(1) : r_cols;
    assign n_r1 = (r_rows   == '0) ? CN'(1) : r_rows;

    always_ff @(posedge i_clk) begin
        r_w1    <= n_w1;
        r_h1    <= n_h1;
        r_c1    <= n_c1;
        r_r1    <= n_r1;
        r_sel_x <= (PW'(n_w1) * PW'(n_r1)) <= (PW'(n_h1) * PW'(n_c1));
    end

    // second step: pitch, full-cover test, corner and inner numerators
    logic [CB-1:0]  n_ps;
    logic [CN-1:0]  n_pn;
    logic           r_full;
    logic [DW1-1:0] r_cnum, r_inum;
    logic [KW-1:0]  r_kdiv;

    assign n_ps = r_sel_x ? r_w1 : r_h1;
    assign n_pn = r_sel_x ? r_c1 : r_r1;

    always_ff @(posedge i_clk) begin
        r_full <= CPW'(n_ps) < (CPW'(n_pn) * CPW'(ldm_pkg::MIN_PITCH));
        r_cnum <= ((DW1'(n_ps) * DW1'(ldm_pkg::CORNER_MILLI)) << FB)
                  + DW1'(n_pn) * DW1'(ldm_pkg::MILLI_HALF);
        r_inum <= ((DW1'(n_ps) * DW1'(ldm_pkg::INNER_MILLI)) << FB)
                  + DW1'(n_pn) * DW1'(ldm_pkg::MILLI_HALF);
        r_kdiv <= KW'(n_pn) * KW'(ldm_pkg::MILLI);
    end

    // ---------------- pixel pipeline ----------------
    logic en;
    logic r8_vld;

    assign en      = !r8_vld || i_ready;
    assign o_ready = en;

    // input stage
    logic          r0_vld;
    logic [CB-1:0] r0_x, r0_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (en) begin
            r0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_x <= i_pixel_x;
            r0_y <= i_pixel_y;
        end
    end

    // scale by LED count
    logic          r1_vld;
    logic [PW-1:0] r1_px, r1_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= r0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_px <= PW'(r0_x) * PW'(r_c1);
            r1_py <= PW'(r0_y) * PW'(r_r1);
        end
    end

    // cell divides: remainder gives the position inside the cell; also the corner and inner divides
    logic           d1_vld, d1_full, d1y_vld, d1c_vld, d1i_vld, d1y_side, d1c_side, d1i_side;
    logic [CB-1:0]  d1_remx, d1_remy;
    logic [DW1-1:0] d1x_quo, d1y_quo, d1_cq, d1_iq;
    logic [KW-1:0]  d1c_rem, d1i_rem;

    ldm_div_pipe #(.DW(DW1), .VW(CB), .SW(1)) u_div_cx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(r1_vld), .i_num(DW1'(r1_px)), .i_div(r_w1), .i_side(r_full),
        .o_vld(d1_vld), .o_quo(d1x_quo), .o_rem(d1_remx), .o_side(d1_full)
    );

    ldm_div_pipe #(.DW(DW1), .VW(CB), .SW(1)) u_div_cy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(r1_vld), .i_num(DW1'(r1_py)), .i_div(r_h1), .i_side(1'b0),
        .o_vld(d1y_vld), .o_quo(d1y_quo), .o_rem(d1_remy), .o_side(d1y_side)
    );

    ldm_div_pipe #(.DW(DW1), .VW(KW), .SW(1)) u_div_corner (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(r1_vld), .i_num(r_cnum), .i_div(r_kdiv), .i_side(1'b0),
        .o_vld(d1c_vld), .o_quo(d1_cq), .o_rem(d1c_rem), .o_side(d1c_side)
    );

    ldm_div_pipe #(.DW(DW1), .VW(KW), .SW(1)) u_div_inner (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(r1_vld), .i_num(r_inum), .i_div(r_kdiv), .i_side(1'b0),
        .o_vld(d1i_vld), .o_quo(d1_iq), .o_rem(d1i_rem), .o_side(d1i_side)
    );

    // offset numerators: |2*rem + C - W| scaled up, plus C for rounding
    logic [DFW-1:0] s2_tx, s2_ty, s2_ax, s2_ay;
    logic [DW2-1:0] n2_numx, n2_numy;
    logic           r2_vld, r2_full;
    logic [DW2-1:0] r2_numx, r2_numy;
    logic [LW-1:0]  r2_corner, r2_inner;

    assign s2_tx = DFW'({d1_remx, 1'b0}) + DFW'(r_c1) - DFW'(r_w1);
    assign s2_ty = DFW'({d1_remy, 1'b0}) + DFW'(r_r1) - DFW'(r_h1);
    assign s2_ax = s2_tx[DFW-1] ? DFW'(-s2_tx) : s2_tx;
    assign s2_ay = s2_ty[DFW-1] ? DFW'(-s2_ty) : s2_ty;
    assign n2_numx = DW2'({s2_ax[CB:0], {FB{1'b0}}}) + DW2'(r_c1);
    assign n2_numy = DW2'({s2_ay[CB:0], {FB{1'b0}}}) + DW2'(r_r1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_numx   <= n2_numx;
            r2_numy   <= n2_numy;
            r2_corner <= d1_cq[LW-1:0];
            r2_inner  <= d1_iq[LW-1:0];
            r2_full   <= d1_full;
        end
    end

    // offset divides by 2*count
    logic           d2_vld, d2y_vld, d2y_side;
    logic [DW2-1:0] d2_qx, d2_qy;
    logic [CN:0]    d2x_rem, d2y_rem;
    logic [2*LW:0]  d2_side;
    logic [LW-1:0]  d2_corner, d2_inner;
    logic           d2_full;

    ldm_div_pipe #(.DW(DW2), .VW(CN+1), .SW(2*LW+1)) u_div_ox (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(r2_vld), .i_num(r2_numx), .i_div({r_c1, 1'b0}),
        .i_side({r2_corner, r2_inner, r2_full}),
        .o_vld(d2_vld), .o_quo(d2_qx), .o_rem(d2x_rem), .o_side(d2_side)
    );

    ldm_div_pipe #(.DW(DW2), .VW(CN+1), .SW(1)) u_div_oy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(r2_vld), .i_num(r2_numy), .i_div({r_r1, 1'b0}), .i_side(1'b0),
        .o_vld(d2y_vld), .o_quo(d2_qy), .o_rem(d2y_rem), .o_side(d2y_side)
    );

    assign {d2_corner, d2_inner, d2_full} = d2_side;

    // distance beyond the straight edges
    logic          r3_vld, r3_full;
    logic [LW-1:0] r3_dx, r3_dy, r3_corner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_dx     <= (d2_qx[LW-1:0] > d2_inner) ? (d2_qx[LW-1:0] - d2_inner) : '0;
            r3_dy     <= (d2_qy[LW-1:0] > d2_inner) ? (d2_qy[LW-1:0] - d2_inner) : '0;
            r3_corner <= d2_corner;
            r3_full   <= d2_full;
        end
    end

    // squares
    logic            r4_vld, r4_full;
    logic [2*LW-1:0] r4_sqx, r4_sqy;
    logic [LW-1:0]   r4_corner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_sqx    <= (2*LW)'(r3_dx) * (2*LW)'(r3_dx);
            r4_sqy    <= (2*LW)'(r3_dy) * (2*LW)'(r3_dy);
            r4_corner <= r3_corner;
            r4_full   <= r3_full;
        end
    end

    // sum of squares
    logic            r5_vld, r5_full;
    logic [2*RB-1:0] r5_sum;
    logic [LW-1:0]   r5_corner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_sum    <= (2*RB)'(r4_sqx) + (2*RB)'(r4_sqy);
            r5_corner <= r4_corner;
            r5_full   <= r4_full;
        end
    end

    // root
    logic          sq_vld, sq_full;
    logic [RB-1:0] sq_root;
    logic [RB:0]   sq_rem;
    logic [LW-1:0] sq_corner;

    ldm_sqrt_pipe #(.RB(RB), .SW(LW+1)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(r5_vld), .i_val(r5_sum), .i_side({r5_corner, r5_full}),
        .o_vld(sq_vld), .o_root(sq_root), .o_rem(sq_rem),
        .o_side({sq_corner, sq_full})
    );

    // round root to nearest
    logic          r6_vld, r6_full;
    logic [RB:0]   r6_root;
    logic [LW-1:0] r6_corner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_root   <= (RB+1)'(sq_root) + (RB+1)'(sq_rem > (RB+1)'(sq_root));
            r6_corner <= sq_corner;
            r6_full   <= sq_full;
        end
    end

    // coverage = half + corner - root, clamped to 0..one
    logic [CVW-1:0] s7_cov;
    logic [FB:0]    n7_cov;
    logic           r7_vld, r7_full;
    logic [FB:0]    r7_cov;

    assign s7_cov = (CVW'(1) << (FB-1)) + CVW'(r6_corner) - CVW'(r6_root);

    always_comb begin
        if (s7_cov[CVW-1]) begin
            n7_cov = '0;
        end else if (s7_cov > (CVW'(1) << FB)) begin
            n7_cov = (FB+1)'(1) << FB;
        end else begin
            n7_cov = s7_cov[FB:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (en) begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_cov  <= n7_cov;
            r7_full <= r6_full;
        end
    end

    // scale to 0..255, output register
    logic [LVW-1:0] s8_lvl;
    logic [7:0]     r8_level;

    assign s8_lvl = ((LVW'(r7_cov) << 8) - LVW'(r7_cov) + (LVW'(1) << (FB-1))) >> FB;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else if (en) begin
            r8_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_level <= r7_full ? 8'hFF : s8_lvl[7:0];
        end
    end

    assign o_valid          = r8_vld;
    assign o_coverage_level = r8_level;

endmodule
